/* rtl/ndsd_pkg.sv */
// ----------------------------------------------------------------------------
// ndsd_pkg
// Shared types and constants for the notification deframer and status decoder.
// ----------------------------------------------------------------------------
package ndsd_pkg;

  localparam int unsigned FULL_CHUNK_LEN = 17;
  localparam int unsigned CAP_DEPTH      = 15;
  localparam int unsigned LEN_W          = 16;
  localparam int unsigned NUM_LEVELS     = 5;

  localparam logic [7:0] FRAME_HEAD    = 8'h68;
  localparam logic [7:0] READ_CMD      = 8'h05;
  localparam logic [2:0] FIVE_CHANNELS = 3'd5;
  localparam logic [2:0] CC_RESET      = 3'd4;

  typedef logic [LEN_W-1:0] len_t;
  localparam len_t LEN_MAX = '1;

  typedef logic [CAP_DEPTH-1:0][7:0] frame_t;

  typedef enum logic [2:0] {
    OUT_DECODED    = 3'd0,
    OUT_BUFFERED   = 3'd1,
    OUT_TOO_SHORT  = 3'd2,
    OUT_BAD_HEADER = 3'd3,
    OUT_NOT_READ   = 3'd4,
    OUT_CHECKSUM   = 3'd5
  } outcome_t;

  typedef enum logic {
    CFG_CHANNEL_COUNT = 1'b0,
    CFG_MANUAL_MODE   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_of_notification;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [7:0]  lamp_mode;
    logic        led_on;
    logic [15:0] level_one;
    logic [15:0] level_two;
    logic [15:0] level_three;
    logic [15:0] level_four;
    logic [15:0] level_five;
  } out_item_t;

  // frame event from the deframer to the status decoder
  typedef struct packed {
    logic       done;
    logic       decode;
    outcome_t   outcome;
    logic [7:0] fx;
    frame_t     frame;
  } frame_evt_t;

endpackage

/* rtl/ndsd_deframe.sv */
// ----------------------------------------------------------------------------
// ndsd_deframe
// Header strip, key decrypt, chunk capture and frame reassembly.
// ----------------------------------------------------------------------------
module ndsd_deframe import ndsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  in_item_t   item,
  output frame_evt_t evt
);

  localparam logic [1:0] POS_FIRST = 2'd0;
  localparam logic [1:0] POS_KEY   = 2'd2;
  localparam logic [1:0] POS_DATA  = 2'd3;

  logic [1:0] pos_r, pos_nxt;
  logic [7:0] hdr0_r, hdr0_nxt;
  logic [7:0] key_r, key_nxt;
  logic       starts_r, starts_nxt;
  logic [7:0] wxor_r, wxor_nxt;
  len_t       wlen_r, wlen_nxt;
  frame_t     wcap_r, wcap_nxt;
  logic [7:0] kxor_r, kxor_nxt;
  len_t       klen_r, klen_nxt;
  frame_t     kcap_r, kcap_nxt;

  logic           cap;
  logic [7:0]     d;
  logic           starts_cur;
  len_t           wlen_cur;
  logic [7:0]     wxor_cur;
  frame_t         wcap_cur;
  frame_t         kcap_cur;
  logic [LEN_W:0] wr_pos;
  logic [LEN_W:0] ksum;
  len_t           klen_sum;
  logic [7:0]     kxor_sum;
  logic           full;

  always_comb begin
    cap = acc && (pos_r == POS_DATA);
    d   = item.byte_value ^ key_r;

    starts_cur = starts_r;
    if (cap && (wlen_r == '0)) begin
      starts_cur = (d == FRAME_HEAD);
    end

    wlen_cur = wlen_r;
    wxor_cur = wxor_r;
    if (cap) begin
      wxor_cur = wxor_r ^ d;
      if (wlen_r != LEN_MAX) begin
        wlen_cur = wlen_r + 1'b1;
      end
    end

    // follow-up chunks land straight in the frame buffer
    wr_pos = {1'b0, klen_r} + {1'b0, wlen_r};
    for (int i = 0; i < CAP_DEPTH; i++) begin
      wcap_cur[i] = (cap && starts_cur && (wlen_r == LEN_W'(i))) ? d : wcap_r[i];
      kcap_cur[i] = (cap && !starts_cur && (wr_pos == (LEN_W+1)'(i))) ? d : kcap_r[i];
    end

    ksum     = {1'b0, klen_r} + {1'b0, wlen_cur};
    klen_sum = ksum[LEN_W] ? LEN_MAX : ksum[LEN_W-1:0];
    kxor_sum = kxor_r ^ wxor_cur;
    full     = (wlen_cur == LEN_W'(FULL_CHUNK_LEN));

    pos_nxt    = pos_r;
    hdr0_nxt   = hdr0_r;
    key_nxt    = key_r;
    starts_nxt = starts_cur;
    wxor_nxt   = wxor_cur;
    wlen_nxt   = wlen_cur;
    wcap_nxt   = wcap_cur;
    kxor_nxt   = kxor_r;
    klen_nxt   = klen_r;
    kcap_nxt   = kcap_cur;

    evt         = '0;
    evt.outcome = OUT_TOO_SHORT;

    if (acc) begin
      if (pos_r == POS_FIRST) begin
        hdr0_nxt = item.byte_value;
      end
      if (pos_r == POS_KEY) begin
        key_nxt = hdr0_r ^ item.byte_value;
      end
      if (pos_r != POS_DATA) begin
        pos_nxt = pos_r + 1'b1;
      end
      if (item.last_of_notification) begin
        evt.done   = 1'b1;
        pos_nxt    = '0;
        starts_nxt = 1'b0;
        wxor_nxt   = '0;
        wlen_nxt   = '0;
        wcap_nxt   = '0;
        if (wlen_cur == '0) begin
          evt.outcome = OUT_TOO_SHORT;
        end else if (starts_cur) begin
          if (full) begin
            kcap_nxt    = wcap_cur;
            kxor_nxt    = wxor_cur;
            klen_nxt    = wlen_cur;
            evt.outcome = OUT_BUFFERED;
          end else begin
            evt.decode = 1'b1;
            evt.frame  = wcap_cur;
            evt.fx     = wxor_cur;
          end
        end else begin
          if (full) begin
            kxor_nxt    = kxor_sum;
            klen_nxt    = klen_sum;
            evt.outcome = OUT_BUFFERED;
          end else begin
            evt.decode = 1'b1;
            evt.frame  = kcap_cur;
            evt.fx     = kxor_sum;
            kcap_nxt   = '0;
            kxor_nxt   = '0;
            klen_nxt   = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      hdr0_r   <= '0;
      key_r    <= '0;
      starts_r <= 1'b0;
      wxor_r   <= '0;
      wlen_r   <= '0;
      wcap_r   <= '0;
      kxor_r   <= '0;
      klen_r   <= '0;
      kcap_r   <= '0;
    end else begin
      pos_r    <= pos_nxt;
      hdr0_r   <= hdr0_nxt;
      key_r    <= key_nxt;
      starts_r <= starts_nxt;
      wxor_r   <= wxor_nxt;
      wlen_r   <= wlen_nxt;
      wcap_r   <= wcap_nxt;
      kxor_r   <= kxor_nxt;
      klen_r   <= klen_nxt;
      kcap_r   <= kcap_nxt;
    end
  end

endmodule

/* rtl/ndsd_status.sv */
// ----------------------------------------------------------------------------
// ndsd_status
// Frame check and lamp status registers.
// ----------------------------------------------------------------------------
module ndsd_status import ndsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  frame_evt_t evt,
  input  logic [2:0] channel_count,
  input  logic [7:0] manual_mode_code,
  output out_item_t  result
);

  logic [7:0]                  mode_r, mode_nxt;
  logic                        on_r, on_nxt;
  logic [NUM_LEVELS-1:0][15:0] lev_r, lev_nxt;
  outcome_t                    outcome;

  always_comb begin
    mode_nxt = mode_r;
    on_nxt   = on_r;
    lev_nxt  = lev_r;
    outcome  = evt.outcome;
    if (evt.decode) begin
      priority if (evt.frame[0] != FRAME_HEAD) begin
        outcome = OUT_BAD_HEADER;
      end else if (evt.frame[1] != READ_CMD) begin
        outcome = OUT_NOT_READ;
      end else if (evt.fx != '0) begin
        outcome = OUT_CHECKSUM;
      end else begin
        outcome  = OUT_DECODED;
        mode_nxt = evt.frame[2];
        on_nxt   = (evt.frame[3] != '0);
        if (evt.frame[2] == manual_mode_code) begin
          for (int k = 0; k < NUM_LEVELS - 1; k++) begin
            lev_nxt[k] = {evt.frame[6 + 2 * k], evt.frame[5 + 2 * k]};
          end
          if (channel_count == FIVE_CHANNELS) begin
            lev_nxt[NUM_LEVELS-1] = {evt.frame[14], evt.frame[13]};
          end
        end else begin
          lev_nxt = '0;
        end
      end
    end

    result.outcome     = outcome;
    result.lamp_mode   = mode_nxt;
    result.led_on      = on_nxt;
    result.level_one   = lev_nxt[0];
    result.level_two   = lev_nxt[1];
    result.level_three = lev_nxt[2];
    result.level_four  = lev_nxt[3];
    result.level_five  = lev_nxt[4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
      on_r   <= 1'b0;
      lev_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      on_r   <= on_nxt;
      lev_r  <= lev_nxt;
    end
  end

endmodule

/* rtl/notify_deframe_status_decoder.sv */
// ----------------------------------------------------------------------------
// notify_deframe_status_decoder
// Notification deframer and lamp status decoder, top level.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data) takes one raw notification byte
// per item, with a flag on the final byte of each notification. Every item
// is taken while in_stall is low, one item per cycle sustained when not stalled.
// The result channel (out_valid/out_stall/out_data) carries one item for each
// notification, in the cycle after its final byte: the outcome code and the
// stored mode, on flag and five channel levels after that notification.
// Other bytes give no result.
// The result sits in an output register; in_stall rises only while a result
// is held there and out_stall is high, and no deframer or status state moves during a stall.
// The config port (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the channel
// count (index 0) and the manual mode code (index 1); cfg_ready is always
// high. Write it only while no notification is in flight.
// Synchronous reset clears the frame buffer, chunk state and lamp status,
// sets channel count to four and the manual mode code to zero.
// ----------------------------------------------------------------------------
module notify_deframe_status_decoder import ndsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  logic [2:0] chan_count_r;
  logic [7:0] manual_r;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r;
  logic       in_acc;
  frame_evt_t evt;
  out_item_t  result;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_count_r <= CC_RESET;
      manual_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CHANNEL_COUNT: chan_count_r <= cfg_data[2:0];
        CFG_MANUAL_MODE:   manual_r     <= cfg_data;
        default:           manual_r     <= manual_r;
      endcase
    end
  end

  ndsd_deframe u_deframe (
    .clk  (clk),
    .rst_n(rst_n),
    .acc  (in_acc),
    .item (in_data),
    .evt  (evt)
  );

  ndsd_status u_status (
    .clk             (clk),
    .rst_n           (rst_n),
    .evt             (evt),
    .channel_count   (chan_count_r),
    .manual_mode_code(manual_r),
    .result          (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (evt.done) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.done) begin
      out_data_r <= result;
    end
  end

endmodule
